FILE: design/wlr_pkg.sv
// Shared types and constants of the waveform line rasterizer.
package wlr_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int MAX_PLOT_SIZE = 63;
  localparam int COORD_BITS    = 11;

  localparam int REL_BITS    = $clog2(MAX_PLOT_SIZE + 1);
  localparam int ORIGIN_BITS = 10;
  localparam int COUNT_BITS  = 16;
  localparam int RANGE_BITS  = 16;
  localparam int NUM_BITS    = COUNT_BITS + REL_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int SEG_DEPTH   = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PLOT_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PLOT_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_X_ORIGIN     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Y_ORIGIN     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_VALUE    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DATA_RANGE   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_COUNT = 3'd6;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          trace_start;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [REL_BITS-1:0]           plot_width;
    logic [REL_BITS-1:0]           plot_height;
    logic [ORIGIN_BITS-1:0]        x_origin;
    logic [ORIGIN_BITS-1:0]        y_origin;
    logic signed [SAMPLE_BITS-1:0] min_value;
    logic [RANGE_BITS-1:0]         data_range;
    logic [COUNT_BITS-1:0]         sample_count;
  } cfg_t;

  // One line segment in plot-relative coordinates.
  typedef struct packed {
    logic [REL_BITS-1:0] x0;
    logic [REL_BITS-1:0] y0;
    logic [REL_BITS-1:0] x1;
    logic [REL_BITS-1:0] y1;
  } seg_t;

endpackage

FILE: design/wlr_div.sv
// Iterative divider, one quotient bit per cycle, for quotients below 2**REL_BITS.
module wlr_div
  import wlr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [NUM_BITS-1:0]   dividend,
  input  logic [RANGE_BITS-1:0] divisor,
  output logic                  done,
  output logic [REL_BITS-1:0]   quotient
);

  localparam int CNT_BITS = $clog2(REL_BITS);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [NUM_BITS-1:0] rem_r, rem_nxt;
  logic [NUM_BITS-1:0] dsh_r, dsh_nxt;
  logic [REL_BITS-1:0] q_r, q_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                ge;

  assign ge = (rem_r >= dsh_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = dividend;
      dsh_nxt  = NUM_BITS'(divisor) << (REL_BITS - 1);
      q_nxt    = '0;
      cnt_nxt  = CNT_BITS'(REL_BITS - 1);
    end else if (busy_r) begin
      // Subtract the shifted divisor where it fits, then shift it down.
      if (ge) rem_nxt = rem_r - dsh_r;
      q_nxt   = {q_r[REL_BITS-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: design/wlr_front.sv
// Front end: takes samples, maps them to plot points and queues line segments.
module wlr_front
  import wlr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  output logic     seg_push,
  output seg_t     seg_data,
  input  logic     seg_full
);

  typedef enum logic [2:0] {
    S_IDLE, S_CLAMP, S_MUL, S_DIV_COL, S_DIV_ROW, S_PUSH
  } state_t;

  state_t                        state_r, state_nxt;
  logic [COUNT_BITS-1:0]         sample_index_r, sample_index_nxt;
  logic [REL_BITS-1:0]           prev_col_r, prev_col_nxt;
  logic [REL_BITS-1:0]           prev_row_r, prev_row_nxt;
  logic [COUNT_BITS-1:0]         idx_r, idx_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [RANGE_BITS-1:0]         d_r, d_nxt;
  logic [NUM_BITS-1:0]           col_num_r, col_num_nxt;
  logic [NUM_BITS-1:0]           row_num_r, row_num_nxt;
  logic [REL_BITS-1:0]           col_r, col_nxt;
  logic [REL_BITS-1:0]           row_r, row_nxt;
  logic                          div_start_r, div_start_nxt;

  logic [COUNT_BITS-1:0]   n_eff;
  logic [COUNT_BITS-1:0]   idx_in;
  logic signed [SAMPLE_BITS:0] diff;
  logic [NUM_BITS-1:0]     div_dividend;
  logic [RANGE_BITS-1:0]   div_divisor;
  logic                    div_done;
  logic [REL_BITS-1:0]     div_q;

  assign n_eff  = (cfg.sample_count == '0) ? COUNT_BITS'(1) : cfg.sample_count;
  assign idx_in = in_data.trace_start ? '0 : sample_index_r;
  assign diff   = {sample_r[SAMPLE_BITS-1], sample_r}
                - {cfg.min_value[SAMPLE_BITS-1], cfg.min_value};

  assign div_dividend = (state_r == S_DIV_ROW) ? row_num_r : col_num_r;
  assign div_divisor  = (state_r == S_DIV_ROW) ? cfg.data_range : n_eff;

  wlr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt        = state_r;
    sample_index_nxt = sample_index_r;
    prev_col_nxt     = prev_col_r;
    prev_row_nxt     = prev_row_r;
    idx_nxt          = idx_r;
    sample_nxt       = sample_r;
    d_nxt            = d_r;
    col_num_nxt      = col_num_r;
    row_num_nxt      = row_num_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    div_start_nxt    = 1'b0;
    seg_push         = 1'b0;
    case (state_r)
      S_IDLE: begin
        // Drop samples past the end of the trace.
        if (in_push && (idx_in < n_eff)) begin
          idx_nxt    = idx_in;
          sample_nxt = in_data.sample;
          state_nxt  = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if (diff[SAMPLE_BITS]) begin
          d_nxt = '0;
        end else if (diff[SAMPLE_BITS-1:0] > cfg.data_range) begin
          d_nxt = cfg.data_range;
        end else begin
          d_nxt = diff[SAMPLE_BITS-1:0];
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        col_num_nxt   = NUM_BITS'(idx_r) * NUM_BITS'(cfg.plot_width);
        row_num_nxt   = NUM_BITS'(d_r) * NUM_BITS'(cfg.plot_height);
        div_start_nxt = 1'b1;
        state_nxt     = S_DIV_COL;
      end
      S_DIV_COL: begin
        if (div_done) begin
          col_nxt = div_q;
          if (cfg.data_range == '0) begin
            row_nxt   = cfg.plot_height;
            state_nxt = S_PUSH;
          end else begin
            div_start_nxt = 1'b1;
            state_nxt     = S_DIV_ROW;
          end
        end
      end
      S_DIV_ROW: begin
        if (div_done) begin
          row_nxt   = cfg.plot_height - div_q;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        // The first point of a trace only seeds the walk.
        if ((idx_r == '0) || !seg_full) begin
          seg_push         = (idx_r != '0);
          prev_col_nxt     = col_r;
          prev_row_nxt     = row_r;
          sample_index_nxt = idx_r + 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      sample_index_r <= '0;
      prev_col_r     <= '0;
      prev_row_r     <= '0;
      div_start_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      sample_index_r <= sample_index_nxt;
      prev_col_r     <= prev_col_nxt;
      prev_row_r     <= prev_row_nxt;
      div_start_r    <= div_start_nxt;
    end
    idx_r     <= idx_nxt;
    sample_r  <= sample_nxt;
    d_r       <= d_nxt;
    col_num_r <= col_num_nxt;
    row_num_r <= row_num_nxt;
    col_r     <= col_nxt;
    row_r     <= row_nxt;
  end

  assign in_full  = (state_r != S_IDLE);
  assign seg_data = '{x0: prev_col_r, y0: prev_row_r, x1: col_r, y1: row_r};

endmodule

FILE: design/wlr_seg_fifo.sv
// Short segment queue between the front end and the line walker.
module wlr_seg_fifo
  import wlr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  seg_t push_data,
  output logic full,
  input  logic pop,
  output seg_t pop_data,
  output logic empty
);

  localparam int PTR_BITS = $clog2(SEG_DEPTH);
  localparam int CNT_BITS = $clog2(SEG_DEPTH + 1);

  seg_t                entry_r [SEG_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == CNT_BITS'(SEG_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(SEG_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(SEG_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

  assign pop_data = entry_r[rd_ptr_r];

endmodule

FILE: design/wlr_walker.sv
// Back end: Bresenham walk of each segment into an output register.
module wlr_walker
  import wlr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      seg_empty,
  input  seg_t      seg_data,
  output logic      seg_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  localparam int ERR_BITS = REL_BITS + 3;

  logic                       busy_r, busy_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_data_r, out_data_nxt;
  logic [REL_BITS-1:0]        x_r, x_nxt, y_r, y_nxt;
  logic [REL_BITS-1:0]        xe_r, xe_nxt, ye_r, ye_nxt;
  logic [REL_BITS-1:0]        dx_r, dx_nxt, dy_r, dy_nxt;
  logic                       sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [ERR_BITS-1:0] err_r, err_nxt;

  logic                       can_load;
  logic                       last;
  logic signed [ERR_BITS-1:0] e2, ndy, pdx, err_step;
  logic [REL_BITS-1:0]        ldx, ldy;

  assign can_load = !out_valid_r || out_pop;
  assign last     = (x_r == xe_r) && (y_r == ye_r);
  assign e2       = err_r <<< 1;
  assign ndy      = -$signed(ERR_BITS'(dy_r));
  assign pdx      = $signed(ERR_BITS'(dx_r));
  assign ldx      = (seg_data.x1 > seg_data.x0) ? seg_data.x1 - seg_data.x0
                                                : seg_data.x0 - seg_data.x1;
  assign ldy      = (seg_data.y1 > seg_data.y0) ? seg_data.y1 - seg_data.y0
                                                : seg_data.y0 - seg_data.y1;

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    xe_nxt        = xe_r;
    ye_nxt        = ye_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    err_nxt       = err_r;
    err_step      = err_r;
    seg_pop       = 1'b0;
    if (out_pop) out_valid_nxt = 1'b0;
    if (busy_r) begin
      if (can_load) begin
        out_valid_nxt = 1'b1;
        out_data_nxt.pixel_x    = COORD_BITS'(x_r) + COORD_BITS'(cfg.x_origin);
        out_data_nxt.pixel_y    = COORD_BITS'(y_r) + COORD_BITS'(cfg.y_origin);
        out_data_nxt.last_pixel = last;
        if (last) begin
          busy_nxt = 1'b0;
        end else begin
          // Advance one pixel along the major and/or minor axis.
          if (e2 > ndy) begin
            err_step = err_step - pdx + pdx + ndy;
            x_nxt    = sx_r ? x_r + 1'b1 : x_r - 1'b1;
          end
          if (e2 < pdx) begin
            err_step = err_step + pdx;
            y_nxt    = sy_r ? y_r + 1'b1 : y_r - 1'b1;
          end
          err_nxt = err_step;
        end
      end
    end else if (!seg_empty) begin
      seg_pop  = 1'b1;
      busy_nxt = 1'b1;
      x_nxt    = seg_data.x0;
      y_nxt    = seg_data.y0;
      xe_nxt   = seg_data.x1;
      ye_nxt   = seg_data.y1;
      dx_nxt   = ldx;
      dy_nxt   = ldy;
      sx_nxt   = (seg_data.x0 < seg_data.x1);
      sy_nxt   = (seg_data.y0 < seg_data.y1);
      err_nxt  = $signed(ERR_BITS'(ldx)) - $signed(ERR_BITS'(ldy));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    xe_r       <= xe_nxt;
    ye_r       <= ye_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    err_r      <= err_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/waveform_line_rasterizer.sv
// Top level of the waveform line rasterizer: registers, front end, queue, walker.
//
// Usage: push one signed sample per transaction on the in_ side (push/full).
// Set trace_start on the first sample of a trace. Each sample after the
// first of a trace yields a run of pixels on the out_ side (empty/pop): the
// Bresenham line from the previous point to the new one, both ends included,
// last_pixel set on the final pixel of the run.
// Configuration: write cfg_wdata into register cfg_index while cfg_we is high;
// write only while the block is idle.
// Sample path: full stays high through clamp, multiply, two divisions on the
// shared divider and push; with a zero range the row division is skipped.
// The walker emits one pixel per cycle while the output register is free,
// max(|dx|,|dy|)+1 pixels per segment after a separate load step. A two-entry
// segment queue lets the front end work on the next sample while the walker
// drains the current line.
// Reset (synchronous, rst_n low) restores default registers, starts a fresh
// trace and empties the queue and output register.
// Stalls: while pop stays low the output register holds its pixel, the
// walker waits, the queue fills, and full rises to hold off the sender.
module waveform_line_rasterizer
  import wlr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  in_item_t                 in_data,
  output logic                     out_empty,
  input  logic                     out_pop,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  logic seg_push, seg_full, seg_pop, seg_empty;
  seg_t seg_in, seg_out;

  // Register file: decode the index and truncate data to each field.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PLOT_WIDTH:   cfg_nxt.plot_width   = cfg_wdata[REL_BITS-1:0];
        CFG_PLOT_HEIGHT:  cfg_nxt.plot_height  = cfg_wdata[REL_BITS-1:0];
        CFG_X_ORIGIN:     cfg_nxt.x_origin     = cfg_wdata[ORIGIN_BITS-1:0];
        CFG_Y_ORIGIN:     cfg_nxt.y_origin     = cfg_wdata[ORIGIN_BITS-1:0];
        CFG_MIN_VALUE:    cfg_nxt.min_value    = $signed(cfg_wdata[SAMPLE_BITS-1:0]);
        CFG_DATA_RANGE:   cfg_nxt.data_range   = cfg_wdata[RANGE_BITS-1:0];
        CFG_SAMPLE_COUNT: cfg_nxt.sample_count = cfg_wdata[COUNT_BITS-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.plot_width   <= REL_BITS'(MAX_PLOT_SIZE);
      cfg_r.plot_height  <= REL_BITS'(MAX_PLOT_SIZE);
      cfg_r.x_origin     <= '0;
      cfg_r.y_origin     <= '0;
      cfg_r.min_value    <= '0;
      cfg_r.data_range   <= '0;
      cfg_r.sample_count <= COUNT_BITS'(64);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: map samples to points and queue segments.
  wlr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .seg_push (seg_push),
    .seg_data (seg_in),
    .seg_full (seg_full)
  );

  // Decouple point mapping from pixel walking.
  wlr_seg_fifo u_seg_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (seg_push),
    .push_data (seg_in),
    .full      (seg_full),
    .pop       (seg_pop),
    .pop_data  (seg_out),
    .empty     (seg_empty)
  );

  // Back end: walk each segment one pixel per cycle while the output register is free; origins apply here.
  wlr_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .seg_empty (seg_empty),
    .seg_data  (seg_out),
    .seg_pop   (seg_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
